// ===== hdl/crdg_pkg.sv =====
// Shared types and constants for the camera ray direction generator.
// Holds the channel payload structs, register indexes and datapath widths.
// No dependencies.
package crdg_pkg;

    // Channel payload widths
    localparam int COORD_W = 17;
    localparam int DIR_W   = 16;

    // Configuration port
    localparam int APB_DATA_W   = 64;
    localparam int PADDR_W      = 5;
    localparam int REG_SEL_LSB  = 3;
    localparam int REG_IDX_W    = PADDR_W - REG_SEL_LSB;

    localparam logic [REG_IDX_W-1:0] REG_BASE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_HORIZ = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_VERT  = 2'd2;

    // Base vector is scaled by 2^16 to line up with the coordinate products
    localparam int COORD_SHIFT = 16;

    // Normalization brings the largest magnitude into [2^29, 2^30)
    localparam int NORM_POS = 29;
    localparam int B_W      = NORM_POS + 1;
    localparam int SQ_W     = 2 * B_W;
    localparam int SUM_W    = SQ_W + 2;

    // Integer square root of the sum of squares
    localparam int ROOT_W     = 31;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int RES_W      = SUM_W + 1;

    // Division of each normalized component by the length
    localparam int Q_W   = 16;
    localparam int QFRAC = 15;
    localparam int REM_W = ROOT_W + Q_W;

    localparam logic signed [DIR_W-1:0] DIR_MAX = 16'sh7fff;

    typedef struct packed {
        logic [COORD_W-1:0] u_coord;
        logic [COORD_W-1:0] v_coord;
    } in_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic                    zero_length;
    } out_t;

    // Normalized magnitudes and signs carried alongside the length computation
    typedef struct packed {
        logic                  zero;
        logic [2:0]            neg;
        logic [2:0][B_W-1:0]   mag;
    } side_t;

    typedef struct packed {
        logic       zero;
        logic [2:0] neg;
    } sign_t;

endpackage

// ===== hdl/crdg_regs.sv =====
// Configuration register file behind the APB-style port.
// Holds the base, horizontal and vertical vectors. Depends on crdg_pkg.
module crdg_regs #(
    parameter int COMPONENT_WIDTH = 20
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [crdg_pkg::PADDR_W-1:0]       paddr,
    input  logic [crdg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [crdg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [3*COMPONENT_WIDTH-1:0]       base_dir,
    output logic [3*COMPONENT_WIDTH-1:0]       horiz_span,
    output logic [3*COMPONENT_WIDTH-1:0]       vert_span
);
    import crdg_pkg::*;

    localparam int RW = 3 * COMPONENT_WIDTH;

    logic [RW-1:0]        base_reg;
    logic [RW-1:0]        horiz_reg;
    logic [RW-1:0]        vert_reg;
    logic [REG_IDX_W-1:0] reg_sel;
    logic                 wr_en;

    assign reg_sel = paddr[PADDR_W-1:REG_SEL_LSB];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            horiz_reg <= '0;
            vert_reg  <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_BASE:  base_reg  <= pwdata[RW-1:0];
                REG_HORIZ: horiz_reg <= pwdata[RW-1:0];
                REG_VERT:  vert_reg  <= pwdata[RW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_BASE:  prdata = APB_DATA_W'(base_reg);
            REG_HORIZ: prdata = APB_DATA_W'(horiz_reg);
            REG_VERT:  prdata = APB_DATA_W'(vert_reg);
            default:   prdata = '0;
        endcase
    end

    assign base_dir   = base_reg;
    assign horiz_span = horiz_reg;
    assign vert_span  = vert_reg;

endmodule

// ===== hdl/crdg_front.sv =====
// Front end of the ray pipeline: products, direction sum, magnitudes,
// common normalizing shift, squares and their sum. Depends on crdg_pkg.
module crdg_front #(
    parameter int COMPONENT_WIDTH = 20
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  crdg_pkg::in_t                  in_data,
    input  logic [3*COMPONENT_WIDTH-1:0]   base_dir,
    input  logic [3*COMPONENT_WIDTH-1:0]   horiz_span,
    input  logic [3*COMPONENT_WIDTH-1:0]   vert_span,
    output logic                           out_valid,
    output logic [crdg_pkg::SUM_W-1:0]     out_sum,
    output crdg_pkg::side_t                out_side
);
    import crdg_pkg::*;

    localparam int W      = COMPONENT_WIDTH;
    localparam int PW     = W + COORD_W + 1;
    localparam int DW     = W + COORD_W + 2;
    localparam int MW     = DW - 1;
    localparam int LEAD_W = $clog2(MW);
    localparam int SH_W   = MW + NORM_POS;
    localparam int STAGES = 8;

    logic signed [W-1:0]  base_c [3];
    logic signed [W-1:0]  h_c [3];
    logic signed [W-1:0]  v_c [3];

    logic [STAGES-1:0]    vld_reg;

    logic signed [PW-1:0] ph_reg [3];
    logic signed [PW-1:0] ph_next [3];
    logic signed [PW-1:0] pv_reg [3];
    logic signed [PW-1:0] pv_next [3];

    logic signed [DW-1:0] d_reg [3];
    logic signed [DW-1:0] d_next [3];

    logic [2:0]           neg3_reg;
    logic [2:0]           neg3_next;
    logic [MW-1:0]        mag3_reg [3];
    logic [MW-1:0]        mag3_next [3];

    logic [2:0]           neg4_reg;
    logic [MW-1:0]        mag4_reg [3];
    logic [MW-1:0]        or4_reg;
    logic [MW-1:0]        or4_next;

    logic [2:0]           neg5_reg;
    logic [MW-1:0]        mag5_reg [3];
    logic [LEAD_W-1:0]    lead5_reg;
    logic [LEAD_W-1:0]    lead5_next;
    logic                 zero5_reg;

    logic [SH_W-1:0]      wide [3];
    side_t                side6_reg;
    side_t                side6_next;

    logic [SQ_W-1:0]      sq7_reg [3];
    logic [SQ_W-1:0]      sq7_next [3];
    side_t                side7_reg;

    logic [SUM_W-1:0]     sum8_reg;
    logic [SUM_W-1:0]     sum8_next;
    side_t                side8_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            base_c[i] = base_dir[i*W +: W];
            h_c[i]    = horiz_span[i*W +: W];
            v_c[i]    = vert_span[i*W +: W];

            ph_next[i] = h_c[i] * $signed({1'b0, in_data.u_coord});
            pv_next[i] = v_c[i] * $signed({1'b0, in_data.v_coord});

            d_next[i] = (DW'(base_c[i]) <<< COORD_SHIFT) + DW'(ph_reg[i]) + DW'(pv_reg[i]);

            neg3_next[i] = d_reg[i][DW-1];
            mag3_next[i] = d_reg[i][DW-1] ? MW'(-d_reg[i]) : MW'(d_reg[i]);

            // Scale by 2^(29 - lead): left shift or truncating right shift
            wide[i] = {mag5_reg[i], {NORM_POS{1'b0}}} >> lead5_reg;
            side6_next.mag[i] = wide[i][B_W-1:0];

            sq7_next[i] = side6_reg.mag[i] * side6_reg.mag[i];
        end
        side6_next.neg  = neg5_reg;
        side6_next.zero = zero5_reg;

        // The leading one of the OR is the leading one of the largest magnitude
        or4_next = mag3_reg[0] | mag3_reg[1] | mag3_reg[2];

        sum8_next = SUM_W'(sq7_reg[0]) + SUM_W'(sq7_reg[1]) + SUM_W'(sq7_reg[2]);
    end

    always_comb begin
        lead5_next = '0;
        for (int k = 0; k < MW; k++) begin
            if (or4_reg[k]) begin
                lead5_next = LEAD_W'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                ph_reg[i]   <= ph_next[i];
                pv_reg[i]   <= pv_next[i];
                d_reg[i]    <= d_next[i];
                mag3_reg[i] <= mag3_next[i];
                mag4_reg[i] <= mag3_reg[i];
                mag5_reg[i] <= mag4_reg[i];
                sq7_reg[i]  <= sq7_next[i];
            end
            neg3_reg  <= neg3_next;
            neg4_reg  <= neg3_reg;
            or4_reg   <= or4_next;
            neg5_reg  <= neg4_reg;
            lead5_reg <= lead5_next;
            zero5_reg <= (or4_reg == '0);
            side6_reg <= side6_next;
            side7_reg <= side6_reg;
            sum8_reg  <= sum8_next;
            side8_reg <= side7_reg;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_sum   = sum8_reg;
    assign out_side  = side8_reg;

endmodule

// ===== hdl/crdg_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Carries the normalized components alongside. Depends on crdg_pkg.
module crdg_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [crdg_pkg::SUM_W-1:0]    in_sum,
    input  crdg_pkg::side_t               in_side,
    output logic                          out_valid,
    output logic [crdg_pkg::ROOT_W-1:0]   out_root,
    output crdg_pkg::side_t               out_side
);
    import crdg_pkg::*;

    logic [SQRT_STEPS-1:0] vld_reg;

    logic [RES_W-1:0] rem_src [SQRT_STEPS];
    logic [RES_W-1:0] root_src [SQRT_STEPS];
    side_t            side_src [SQRT_STEPS];

    logic [RES_W-1:0] trial [SQRT_STEPS];
    logic [RES_W-1:0] step_bit [SQRT_STEPS];
    logic [RES_W-1:0] rem_next [SQRT_STEPS];
    logic [RES_W-1:0] root_next [SQRT_STEPS];

    // The last stage keeps the root and side data but not the remainder
    logic [RES_W-1:0] rem_reg [SQRT_STEPS-1];
    logic [RES_W-1:0] root_reg [SQRT_STEPS];
    side_t            side_reg [SQRT_STEPS];

    always_comb begin
        rem_src[0]  = RES_W'(in_sum);
        root_src[0] = '0;
        side_src[0] = in_side;
        for (int t = 1; t < SQRT_STEPS; t++) begin
            rem_src[t]  = rem_reg[t-1];
            root_src[t] = root_reg[t-1];
            side_src[t] = side_reg[t-1];
        end
    end

    always_comb begin
        for (int t = 0; t < SQRT_STEPS; t++) begin
            step_bit[t] = RES_W'(1) << (2 * (SQRT_STEPS - 1 - t));
            trial[t]    = root_src[t] + step_bit[t];
            if (rem_src[t] >= trial[t]) begin
                rem_next[t]  = rem_src[t] - trial[t];
                root_next[t] = (root_src[t] >> 1) + step_bit[t];
            end else begin
                rem_next[t]  = rem_src[t];
                root_next[t] = root_src[t] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SQRT_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int t = 0; t < SQRT_STEPS - 1; t++) begin
                rem_reg[t] <= rem_next[t];
            end
            for (int t = 0; t < SQRT_STEPS; t++) begin
                root_reg[t] <= root_next[t];
                side_reg[t] <= side_src[t];
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign out_root  = root_reg[SQRT_STEPS-1][ROOT_W-1:0];
    assign out_side  = side_reg[SQRT_STEPS-1];

endmodule

// ===== hdl/crdg_div.sv =====
// Pipelined restoring divider: three components over the common length,
// rounded half up, one quotient bit per stage. Depends on crdg_pkg.
module crdg_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [crdg_pkg::ROOT_W-1:0]        in_root,
    input  crdg_pkg::side_t                    in_side,
    output logic                               out_valid,
    output logic [2:0][crdg_pkg::Q_W-1:0]      out_quot,
    output crdg_pkg::sign_t                    out_sign
);
    import crdg_pkg::*;

    // Setup stage: numerator b*2^15 + floor(L/2)
    logic [REM_W-1:0]  num_reg [3];
    logic [REM_W-1:0]  num_next [3];
    logic [ROOT_W-1:0] den_p_reg;
    sign_t             sign_p_reg;
    logic              vld_p_reg;

    logic [Q_W-1:0]    vld_reg;

    logic [REM_W-1:0]  rem_src [Q_W][3];
    logic [Q_W-1:0]    quot_src [Q_W][3];
    logic [ROOT_W-1:0] den_src [Q_W];
    sign_t             sign_src [Q_W];

    logic [REM_W-1:0]  shifted [Q_W][3];
    logic [REM_W-1:0]  rem_next [Q_W][3];
    logic [Q_W-1:0]    quot_next [Q_W][3];

    // The last stage keeps only the quotient and signs
    logic [REM_W-1:0]  rem_reg [Q_W-1][3];
    logic [ROOT_W-1:0] den_reg [Q_W-1];
    logic [Q_W-1:0]    quot_reg [Q_W][3];
    sign_t             sign_reg [Q_W];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num_next[i] = REM_W'({in_side.mag[i], {QFRAC{1'b0}}}) + REM_W'(in_root >> 1);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rem_src[0][i]  = num_reg[i];
            quot_src[0][i] = '0;
        end
        den_src[0]  = den_p_reg;
        sign_src[0] = sign_p_reg;
        for (int t = 1; t < Q_W; t++) begin
            for (int i = 0; i < 3; i++) begin
                rem_src[t][i]  = rem_reg[t-1][i];
                quot_src[t][i] = quot_reg[t-1][i];
            end
            den_src[t]  = den_reg[t-1];
            sign_src[t] = sign_reg[t-1];
        end
    end

    always_comb begin
        for (int t = 0; t < Q_W; t++) begin
            for (int i = 0; i < 3; i++) begin
                shifted[t][i] = REM_W'(den_src[t]) << (Q_W - 1 - t);
                if (rem_src[t][i] >= shifted[t][i]) begin
                    rem_next[t][i]  = rem_src[t][i] - shifted[t][i];
                    quot_next[t][i] = {quot_src[t][i][Q_W-2:0], 1'b1};
                end else begin
                    rem_next[t][i]  = rem_src[t][i];
                    quot_next[t][i] = {quot_src[t][i][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_p_reg <= 1'b0;
            vld_reg   <= '0;
        end else if (en) begin
            vld_p_reg <= in_valid;
            vld_reg   <= {vld_reg[Q_W-2:0], vld_p_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                num_reg[i] <= num_next[i];
            end
            den_p_reg       <= in_root;
            sign_p_reg.zero <= in_side.zero;
            sign_p_reg.neg  <= in_side.neg;
            for (int t = 0; t < Q_W - 1; t++) begin
                for (int i = 0; i < 3; i++) begin
                    rem_reg[t][i] <= rem_next[t][i];
                end
                den_reg[t] <= den_src[t];
            end
            for (int t = 0; t < Q_W; t++) begin
                for (int i = 0; i < 3; i++) begin
                    quot_reg[t][i] <= quot_next[t][i];
                end
                sign_reg[t] <= sign_src[t];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            out_quot[i] = quot_reg[Q_W-1][i];
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_sign  = sign_reg[Q_W-1];

endmodule

// ===== hdl/crdg_out_buf.sv =====
// Two-entry output buffer (head plus skid) on the result channel.
// Stalls the pipeline only once both entries are full. Depends on crdg_pkg.
module crdg_out_buf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  crdg_pkg::out_t  in_data,
    output logic            advance,
    output logic            m_valid,
    input  logic            m_ready,
    output crdg_pkg::out_t  m_data
);
    import crdg_pkg::*;

    out_t head_reg;
    out_t skid_reg;
    logic head_valid_reg;
    logic skid_valid_reg;
    logic push;
    logic pop;

    assign advance = !skid_valid_reg;
    assign push    = in_valid && advance;
    assign pop     = head_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop || !head_valid_reg) begin
            head_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Refill the head from the skid entry first to keep order
    always_ff @(posedge aclk) begin
        if (pop || !head_valid_reg) begin
            head_reg <= skid_valid_reg ? skid_reg : in_data;
        end else if (push) begin
            skid_reg <= in_data;
        end
    end

    assign m_valid = head_valid_reg;
    assign m_data  = head_reg;

endmodule

// ===== hdl/camera_ray_direction_generator.sv =====
// Pinhole camera ray direction generator, top level.
// Uses crdg_pkg, crdg_regs, crdg_front, crdg_sqrt, crdg_div and crdg_out_buf.
//
// Usage:
//   Program base_direction (0x00), horizontal_span (0x08) and vertical_span
//   (0x10) over the APB-style port while no rays are in flight. Each is
//   three signed components packed x, y, z from bit 0 upward.
//   Feed (u_coord, v_coord) on the s_ channel; each transfer yields exactly
//   one unit direction or zero_length result on the m_ channel, in input order.
// Throughput: one ray per cycle, sustained, with m_ready held high.
// Pipeline: an input transfer passes through 8 stages of products, sums,
//   normalization and squares, 31 stages of square root (one root bit
//   each), 17 stages of division (setup plus one quotient bit each) and
//   the output register before its result shows on m_valid.
// Stall: a two-entry output buffer absorbs one extra result; once it is
//   full the whole pipeline holds and s_ready drops, so nothing is lost.
// Reset: aresetn low clears all valid bits and the configuration registers.
module camera_ray_direction_generator #(
    parameter int COMPONENT_WIDTH = 20
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  crdg_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output crdg_pkg::out_t                    m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [crdg_pkg::PADDR_W-1:0]      paddr,
    input  logic [crdg_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [crdg_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import crdg_pkg::*;

    logic [3*COMPONENT_WIDTH-1:0] base_dir;
    logic [3*COMPONENT_WIDTH-1:0] horiz_span;
    logic [3*COMPONENT_WIDTH-1:0] vert_span;

    logic                 advance;
    logic                 front_valid;
    logic [SUM_W-1:0]     front_sum;
    side_t                front_side;
    logic                 sqrt_valid;
    logic [ROOT_W-1:0]    sqrt_root;
    side_t                sqrt_side;
    logic                 div_valid;
    logic [2:0][Q_W-1:0]  div_quot;
    sign_t                div_sign;
    out_t                 result;

    function automatic logic signed [DIR_W-1:0] to_dir(input logic [Q_W-1:0] q,
                                                       input logic neg);
        logic signed [DIR_W-1:0] r;
        if (neg) begin
            r = DIR_W'(~q + Q_W'(1));
        end else if (q[Q_W-1]) begin
            // Plus one saturates
            r = DIR_MAX;
        end else begin
            r = DIR_W'(q);
        end
        return r;
    endfunction

    crdg_regs #(
        .COMPONENT_WIDTH(COMPONENT_WIDTH)
    ) u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .base_dir   (base_dir),
        .horiz_span (horiz_span),
        .vert_span  (vert_span)
    );

    crdg_front #(
        .COMPONENT_WIDTH(COMPONENT_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .in_valid   (s_valid),
        .in_data    (s_data),
        .base_dir   (base_dir),
        .horiz_span (horiz_span),
        .vert_span  (vert_span),
        .out_valid  (front_valid),
        .out_sum    (front_sum),
        .out_side   (front_side)
    );

    crdg_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_valid  (front_valid),
        .in_sum    (front_sum),
        .in_side   (front_side),
        .out_valid (sqrt_valid),
        .out_root  (sqrt_root),
        .out_side  (sqrt_side)
    );

    crdg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_valid  (sqrt_valid),
        .in_root   (sqrt_root),
        .in_side   (sqrt_side),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_sign  (div_sign)
    );

    always_comb begin
        result             = '0;
        result.zero_length = div_sign.zero;
        if (!div_sign.zero) begin
            result.dir_x = to_dir(div_quot[0], div_sign.neg[0]);
            result.dir_y = to_dir(div_quot[1], div_sign.neg[1]);
            result.dir_z = to_dir(div_quot[2], div_sign.neg[2]);
        end
    end

    crdg_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (div_valid),
        .in_data  (result),
        .advance  (advance),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    assign s_ready = advance;

endmodule

// ===== hdl/crdg_checker.sv =====
// Port-level checks on the ray direction generator's result channel.
// Bound to camera_ray_direction_generator; depends on crdg_pkg.
module crdg_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input crdg_pkg::out_t m_data
);
    import crdg_pkg::*;

    // Reset drops any pending result
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A zero-length direction reports all components as zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_length |->
            m_data.dir_x == '0 && m_data.dir_y == '0 && m_data.dir_z == '0)
        else $error("zero_length with nonzero components");

    // A unit vector always has a nonzero component
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.zero_length |->
            m_data.dir_x != '0 || m_data.dir_y != '0 || m_data.dir_z != '0)
        else $error("nonzero direction normalized to all zeros");

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

endmodule

bind camera_ray_direction_generator crdg_checker u_crdg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
